### rtl/civ_pkg.sv
// ----------------------------------------------------------------------------
// civ_pkg
// Shared types, bus symbols and decode helpers for the CI-V frame receiver.
// ----------------------------------------------------------------------------
package civ_pkg;

    // Bus symbols
    localparam logic [7:0] SYM_START  = 8'hFE;
    localparam logic [7:0] SYM_STOP   = 8'hFD;
    localparam logic [7:0] SYM_OK     = 8'hFB;
    localparam logic [7:0] SYM_NG     = 8'hFA;
    localparam logic [7:0] ADDR_BCAST = 8'h00;
    localparam logic [7:0] CMD_EXT    = 8'h1A;
    localparam logic [7:0] SUB_EXT    = 8'h05;

    // Request kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DATA   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    // Configuration register indexes
    localparam logic REG_MASTER  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    // First data byte position for each command shape
    localparam logic [3:0] START_ONE  = 4'd5;
    localparam logic [3:0] START_TWO  = 4'd6;
    localparam logic [3:0] START_FOUR = 4'd8;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SYNC,
        PH_COLLECT
    } t_phase;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  source_addr;
        logic [2:0]  cmd_len;
        logic [31:0] cmd_bytes;
        logic [5:0]  data_len;
        logic [63:0] data_head;
        logic [33:0] value;
    } t_result;

    // Commands that carry a subcommand byte
    function automatic logic is_two_byte(input logic [7:0] c);
        logic hit;
        case (c)
            8'h07, 8'h0E, 8'h13, 8'h14, 8'h15, 8'h16, 8'h19,
            8'h1A, 8'h1B, 8'h1C, 8'h1E, 8'h21, 8'h27: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Position of the first data byte, from the command and the byte after it
    function automatic logic [3:0] data_start(input logic [7:0] c, input logic [7:0] b5);
        logic [3:0] s;
        if (c == CMD_EXT && b5 == SUB_EXT) begin
            s = START_FOUR;
        end else if (is_two_byte(c)) begin
            s = START_TWO;
        end else begin
            s = START_ONE;
        end
        return s;
    endfunction

    // Two BCD digits weighted as they stand, no clamp on digits above nine
    function automatic logic [7:0] bcd_byte(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return 8'((hi << 3) + (hi << 1) + {4'd0, b[3:0]});
    endfunction

    // Weight of a little-endian BCD byte
    function automatic logic [26:0] pow100(input logic [2:0] k);
        logic [26:0] p;
        case (k)
            3'd0:    p = 27'd1;
            3'd1:    p = 27'd100;
            3'd2:    p = 27'd10000;
            3'd3:    p = 27'd1000000;
            3'd4:    p = 27'd100000000;
            default: p = 27'd0;
        endcase
        return p;
    endfunction

endpackage

### rtl/civ_in_if.sv
// ----------------------------------------------------------------------------
// civ_in_if
// Request channel into the receiver: one bus byte or one time tick.
// ----------------------------------------------------------------------------
interface civ_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

### rtl/civ_out_if.sv
// ----------------------------------------------------------------------------
// civ_out_if
// Result channel out of the receiver: one decoded frame outcome.
// ----------------------------------------------------------------------------
interface civ_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  source_addr;
    logic [2:0]  cmd_len;
    logic [31:0] cmd_bytes;
    logic [5:0]  data_len;
    logic [63:0] data_head;
    logic [33:0] value;

    modport source (output valid, output status, output source_addr, output cmd_len,
                    output cmd_bytes, output data_len, output data_head, output value,
                    input ready);
    modport sink   (input valid, input status, input source_addr, input cmd_len,
                    input cmd_bytes, input data_len, input data_head, input value,
                    output ready);
endinterface

### rtl/civ_out_reg.sv
// ----------------------------------------------------------------------------
// civ_out_reg
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module civ_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  civ_pkg::t_result i_res,
    output logic             o_can_load,
    civ_out_if.source        o_out
);
    import civ_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held result leaves this cycle
    assign o_can_load = !r_valid || o_out.ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_res.status;
    assign o_out.source_addr = r_res.source_addr;
    assign o_out.cmd_len     = r_res.cmd_len;
    assign o_out.cmd_bytes   = r_res.cmd_bytes;
    assign o_out.data_len    = r_res.data_len;
    assign o_out.data_head   = r_res.data_head;
    assign o_out.value       = r_res.value;

endmodule

### rtl/civ_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// civ_frame_receiver_top
// CI-V bus frame receiver: sync, address check, command split and decode.
// ----------------------------------------------------------------------------
// Every request (a bus byte or a time tick) is taken while input ready is high
// and a new one may follow in the next; the decode runs in flight as bytes
// arrive, so the stop byte's result is loaded into the result register in the
// cycle after it is taken. Input ready drops only while a result sits in the
// result register and the sink is not taking it. Command bytes, the first eight
// data bytes and both BCD sums are gathered byte by byte, so no frame buffer is
// read back. The user must write master_addr and timeout_ticks through the write
// port only while no frame is in progress; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module civ_frame_receiver_top #(
    parameter int FRAME_MAX = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    civ_in_if.sink      i_in,
    civ_out_if.source   o_out
);
    import civ_pkg::*;

    localparam int LEN_W = $clog2(FRAME_MAX + 1);

    // Control and configuration
    t_phase      r_phase, n_phase;
    logic [LEN_W-1:0] r_len, n_len;
    logic [15:0] r_wait, n_wait;
    logic [7:0]  r_master;
    logic [15:0] r_timeout;

    // Gathered frame contents
    logic [7:0]  r_src, n_src;
    logic [31:0] r_cmdb, n_cmdb;
    logic [3:0]  r_start, n_start;
    logic [63:0] r_head, n_head;
    logic [14:0] r_v2, n_v2;
    logic [33:0] r_v5, n_v5;

    logic        acc, can_load, is_tick, res_valid;
    logic [7:0]  b;
    logic [LEN_W-1:0] pos, didx;
    logic [3:0]  start_cur;
    logic [15:0] wait_inc;
    logic        timed_out, ovf, tgt_bad, in_frame, frame_begin, data_we;
    logic [31:0] cmd_mask;
    t_result     res;

    assign acc     = i_in.valid && i_in.ready;
    assign is_tick = (i_in.cmd == CMD_TICK);
    assign b       = i_in.rx_byte;
    assign pos     = r_len;

    assign wait_inc  = (r_wait != 16'hFFFF) ? 16'(r_wait + 16'd1) : r_wait;
    assign timed_out = (wait_inc >= r_timeout);
    assign ovf       = (pos >= LEN_W'(FRAME_MAX));
    assign tgt_bad   = (pos == LEN_W'(2)) && !(b == ADDR_BCAST || b == r_master);

    // Data start is fixed once the byte after the command is seen
    assign start_cur = (pos == LEN_W'(5)) ? data_start(r_cmdb[7:0], b) : r_start;
    assign didx      = LEN_W'(pos - LEN_W'(start_cur));

    assign frame_begin = acc && !is_tick && (r_phase == PH_IDLE) && (b == SYM_START);
    assign in_frame    = acc && !is_tick && (r_phase == PH_COLLECT) && !ovf;
    assign data_we     = in_frame && (pos >= LEN_W'(5)) && (pos >= LEN_W'(start_cur))
                         && (b != SYM_STOP) && (b != SYM_START);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master  <= 8'hE0;
            r_timeout <= 16'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MASTER:  r_master  <= i_cfg_wdata[7:0];
                REG_TIMEOUT: r_timeout <= i_cfg_wdata;
                default:     r_master  <= r_master;
            endcase
        end
    end

    // Next phase, frame length and tick count
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_wait  = r_wait;
        if (acc) begin
            if (is_tick) begin
                if (r_phase != PH_IDLE) begin
                    n_wait = wait_inc;
                    if (timed_out) begin
                        n_phase = PH_IDLE;
                    end
                end
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        if (b == SYM_START) begin
                            n_len   = LEN_W'(1);
                            n_wait  = 16'd0;
                            n_phase = PH_SYNC;
                        end
                    end
                    PH_SYNC: begin
                        if (b == SYM_START) begin
                            n_len   = LEN_W'(2);
                            n_phase = PH_COLLECT;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_COLLECT: begin
                        if (ovf) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_len = LEN_W'(r_len + LEN_W'(1));
                            if (tgt_bad || b == SYM_START || b == SYM_STOP) begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // Gather source, command bytes, data head and BCD sums
    always_comb begin
        n_src   = r_src;
        n_cmdb  = r_cmdb;
        n_start = r_start;
        n_head  = r_head;
        n_v2    = r_v2;
        n_v5    = r_v5;
        if (frame_begin) begin
            n_cmdb = 32'd0;
            n_head = 64'd0;
            n_v2   = 15'd0;
            n_v5   = 34'd0;
        end
        if (in_frame && pos == LEN_W'(3)) begin
            n_src = b;
        end
        if (in_frame && pos >= LEN_W'(4) && pos <= LEN_W'(7)) begin
            n_cmdb[8*pos[1:0] +: 8] = b;
        end
        if (in_frame && pos == LEN_W'(5)) begin
            n_start = start_cur;
        end
        if (data_we && didx < LEN_W'(8)) begin
            n_head[8*didx[2:0] +: 8] = b;
        end
        if (data_we && didx < LEN_W'(2)) begin
            n_v2 = 15'(r_v2 * 15'd100 + {7'd0, bcd_byte(b)});
        end
        if (data_we && didx < LEN_W'(5)) begin
            n_v5 = 34'(r_v5 + {26'd0, bcd_byte(b)} * {7'd0, pow100(didx[2:0])});
        end
    end

    // Build the result for this request
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        case (start_cur)
            START_ONE:  cmd_mask = 32'h0000_00FF;
            START_TWO:  cmd_mask = 32'h0000_FFFF;
            default:    cmd_mask = 32'hFFFF_FFFF;
        endcase
        if (acc && is_tick) begin
            if (r_phase != PH_IDLE && timed_out) begin
                res_valid  = 1'b1;
                res.status = ST_NONE;
            end
        end else if (acc && r_phase == PH_COLLECT) begin
            if (ovf) begin
                res_valid  = 1'b1;
                res.status = ST_NONE;
            end else if (!tgt_bad && b == SYM_STOP) begin
                res_valid  = 1'b1;
                res.status = ST_REJECT;
                if (pos >= LEN_W'(5)) begin
                    res.source_addr = r_src;
                    if (r_cmdb[7:0] == SYM_OK || r_cmdb[7:0] == SYM_NG) begin
                        res.status    = (r_cmdb[7:0] == SYM_OK) ? ST_OK : ST_REJECT;
                        res.cmd_len   = 3'd1;
                        res.cmd_bytes = {24'd0, r_cmdb[7:0]};
                    end else if (pos >= LEN_W'(start_cur)) begin
                        res.status    = ST_DATA;
                        res.cmd_len   = 3'(start_cur - 4'd4);
                        res.cmd_bytes = r_cmdb & cmd_mask;
                        res.data_len  = 6'(didx);
                        res.data_head = r_head;
                        if (didx == LEN_W'(1)) begin
                            res.value = {26'd0, r_head[7:0]};
                        end else if (didx == LEN_W'(2)) begin
                            res.value = {19'd0, r_v2};
                        end else if (didx == LEN_W'(5)) begin
                            res.value = r_v5;
                        end
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_wait  <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_wait  <= n_wait;
        end
    end

    // Frame content registers
    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_cmdb  <= n_cmdb;
        r_start <= n_start;
        r_head  <= n_head;
        r_v2    <= n_v2;
        r_v5    <= n_v5;
    end

    assign i_in.ready = can_load;

    civ_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

### rtl/civ_chk.sv
// ----------------------------------------------------------------------------
// civ_chk
// Port-level checks on the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module civ_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_status,
    input logic [7:0]  out_source_addr,
    input logic [2:0]  out_cmd_len,
    input logic [31:0] out_cmd_bytes,
    input logic [5:0]  out_data_len,
    input logic [63:0] out_data_head,
    input logic [33:0] out_value
);
    import civ_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status)
            && $stable(out_value) && $stable(out_data_head))
        else $error("stalled result changed");

    // No-message result carries only zeros
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status == ST_NONE |-> out_source_addr == 8'd0
            && out_cmd_len == 3'd0 && out_cmd_bytes == 32'd0 && out_data_len == 6'd0
            && out_data_head == 64'd0 && out_value == 34'd0)
        else $error("no-message result has nonzero fields");

    // Acknowledge carries its own symbol as the only command byte and no data
    a_ok_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status == ST_OK |-> out_cmd_len == 3'd1
            && out_cmd_bytes == {24'd0, SYM_OK} && out_data_len == 6'd0
            && out_data_head == 64'd0 && out_value == 34'd0)
        else $error("acknowledge result malformed");

    // Empty result register never stalls requests
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("request stalled with empty result register");

    // A new result follows a taken request
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result appeared without a request");

endmodule

bind civ_frame_receiver_top civ_chk u_civ_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .in_valid        (i_in.valid),
    .in_ready        (i_in.ready),
    .out_valid       (o_out.valid),
    .out_ready       (o_out.ready),
    .out_status      (o_out.status),
    .out_source_addr (o_out.source_addr),
    .out_cmd_len     (o_out.cmd_len),
    .out_cmd_bytes   (o_out.cmd_bytes),
    .out_data_len    (o_out.data_len),
    .out_data_head   (o_out.data_head),
    .out_value       (o_out.value)
);

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CI-V frame receiver. A queue of bus bytes and
// time ticks feeds a clocked driver. A clocked monitor tracks every accepted
// request in a local frame tracker and compares each decoded frame outcome
// field by field. Both channels idle at random. Directed frames and random,
// mostly well-formed traffic run under several address and timeout settings.
// ----------------------------------------------------------------------------
module tb_top;
    import civ_pkg::*;

    localparam int FRAME_MAX      = 32;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 250;

    // Commands that carry a subcommand byte
    localparam logic [13*8-1:0] SUBCMD_OPS = {
        8'h07, 8'h0E, 8'h13, 8'h14, 8'h15, 8'h16, 8'h19,
        8'h1A, 8'h1B, 8'h1C, 8'h1E, 8'h21, 8'h27
    };

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    civ_in_if  in_ch ();
    civ_out_if out_ch ();

    civ_frame_receiver_top #(
        .FRAME_MAX(FRAME_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Stimulus and expected outcomes
    t_request    requests_queued[$];
    t_result     results_due[$];
    int unsigned items_queued = 0;
    int unsigned tick_pct     = 0;

    // Frame tracker state and its copy of the registers
    t_phase      rx_phase   = PH_IDLE;
    int unsigned frame_len  = 0;
    logic [7:0]  frame_bytes[FRAME_MAX];
    logic [15:0] tick_count = '0;
    logic [7:0]  own_addr   = 8'hE0;
    logic [15:0] tick_limit = 16'd1000;

    // Handshake bookkeeping between the clocked blocks
    bit          request_taken = 0;
    bit          result_taken  = 0;
    bit          send_burst    = 0;
    bit          sink_burst    = 0;
    int unsigned send_gap      = 0;
    int unsigned sink_stall    = 0;
    t_request    next_req;

    // Run statistics
    int unsigned fail_count     = 0;
    int unsigned requests_taken = 0;
    int unsigned idle_cycles    = 0;
    int unsigned settings_seen  = 1;
    int unsigned status_seen[4] = '{0, 0, 0, 0};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit has_subcmd(input logic [7:0] op);
        bit hit;
        hit = 0;
        for (int i = 0; i < 13; i++) begin
            if (SUBCMD_OPS[8*i +: 8] == op) hit = 1;
        end
        return hit;
    endfunction

    function automatic logic [63:0] digit_pair(input logic [7:0] b);
        return {60'd0, b[7:4]} * 10 + {60'd0, b[3:0]};
    endfunction

    // Decode a finished frame; the last held byte is the stop byte
    function automatic t_result decode_frame();
        t_result     res;
        int unsigned first;
        int unsigned dlen;
        logic [7:0]  op;
        logic [63:0] sum;
        res = '0;
        res.status = ST_REJECT;
        if (frame_len < 6) return res;
        res.source_addr = frame_bytes[3];
        op = frame_bytes[4];
        if (op == SYM_OK || op == SYM_NG) begin
            res.status    = (op == SYM_OK) ? ST_OK : ST_REJECT;
            res.cmd_len   = 3'd1;
            res.cmd_bytes = {24'd0, op};
            return res;
        end
        first = has_subcmd(op) ? 6 : 5;
        if (op == CMD_EXT && frame_bytes[5] == SUB_EXT) first = 8;
        // Truncated command keeps only the source address
        if (frame_len - 1 < first) return res;
        dlen = frame_len - 1 - first;
        for (int i = 4; i < first; i++) begin
            res.cmd_bytes[8*(i-4) +: 8] = frame_bytes[i];
        end
        for (int i = 0; i < dlen && i < 8; i++) begin
            res.data_head[8*i +: 8] = frame_bytes[first+i];
        end
        sum = '0;
        if (dlen == 1) begin
            sum = {56'd0, frame_bytes[first]};
        end else if (dlen == 2) begin
            sum = digit_pair(frame_bytes[first]) * 100 + digit_pair(frame_bytes[first+1]);
        end else if (dlen == 5) begin
            for (int i = 5; i > 0; i--) begin
                sum = sum * 100 + digit_pair(frame_bytes[first+i-1]);
            end
        end
        res.status   = ST_DATA;
        res.cmd_len  = 3'(first - 4);
        res.data_len = 6'(dlen);
        res.value    = sum[33:0];
        return res;
    endfunction

    // Advance the frame tracker by one accepted request
    task automatic track_request(input logic cmd, input logic [7:0] b);
        t_result res;
        res = '0;
        res.status = ST_NONE;
        if (cmd == CMD_TICK) begin
            if (rx_phase == PH_IDLE) return;
            if (tick_count != 16'hFFFF) tick_count++;
            if (tick_count >= tick_limit) begin
                rx_phase = PH_IDLE;
                results_due.push_back(res);
            end
            return;
        end
        case (rx_phase)
            PH_IDLE: begin
                if (b == SYM_START) begin
                    frame_bytes[0] = b;
                    frame_len  = 1;
                    tick_count = '0;
                    rx_phase   = PH_SYNC;
                end
            end
            PH_SYNC: begin
                if (b == SYM_START) begin
                    frame_bytes[1] = b;
                    frame_len = 2;
                    rx_phase  = PH_COLLECT;
                end else begin
                    rx_phase = PH_IDLE;
                end
            end
            default: begin
                if (frame_len >= FRAME_MAX) begin
                    // Overflow: drop the frame, report no message
                    rx_phase = PH_IDLE;
                    results_due.push_back(res);
                end else begin
                    frame_bytes[frame_len] = b;
                    frame_len++;
                    if (frame_len == 3 && b != ADDR_BCAST && b != own_addr) begin
                        rx_phase = PH_IDLE;
                    end else if (b == SYM_START) begin
                        rx_phase = PH_IDLE;
                    end else if (b == SYM_STOP) begin
                        rx_phase = PH_IDLE;
                        results_due.push_back(decode_frame());
                    end
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (results_due.size() == 0) begin
            $error("result with no frame outstanding: status %0d", out_ch.status);
            fail_count++;
            return;
        end
        want = results_due.pop_front();
        compare_field("status",      64'(want.status),      64'(out_ch.status));
        compare_field("source_addr", 64'(want.source_addr), 64'(out_ch.source_addr));
        compare_field("cmd_len",     64'(want.cmd_len),     64'(out_ch.cmd_len));
        compare_field("cmd_bytes",   64'(want.cmd_bytes),   64'(out_ch.cmd_bytes));
        compare_field("data_len",    64'(want.data_len),    64'(out_ch.data_len));
        compare_field("data_head",   want.data_head,        out_ch.data_head);
        compare_field("value",       64'(want.value),       64'(out_ch.value));
    endtask

    function automatic int unsigned draw_wait(input bit burst);
        if (burst || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 15);
    endfunction

    // Sample both channels, track and check, watch for a stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                result_taken = 1;
                status_seen[out_ch.status]++;
                check_result();
            end
            if (in_ch.valid && in_ch.ready) begin
                request_taken = 1;
                requests_taken++;
                track_request(in_ch.cmd, in_ch.rx_byte);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Present queued requests, hold until taken, then wait a random gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (request_taken || !in_ch.valid) begin
            request_taken = 0;
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (requests_queued.size() != 0) begin
                next_req = requests_queued.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.cmd     <= next_req.cmd;
                in_ch.rx_byte <= next_req.rx_byte;
                if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
                send_gap = draw_wait(send_burst);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Stall the result channel for a random number of cycles after each take
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (result_taken) begin
                result_taken = 0;
                if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
                sink_stall = draw_wait(sink_burst);
            end
            if (sink_stall > 0) begin
                sink_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic queue_request(input logic cmd, input logic [7:0] b);
        t_request req;
        req.cmd     = cmd;
        req.rx_byte = b;
        requests_queued.push_back(req);
        items_queued++;
    endtask

    // Queue a bus byte, sometimes after a tick
    task automatic queue_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < tick_pct) queue_request(CMD_TICK, 8'($urandom));
        queue_request(CMD_BYTE, b);
    endtask

    task automatic queue_header(input logic [7:0] target, input logic [7:0] src);
        queue_byte(SYM_START);
        queue_byte(SYM_START);
        queue_byte(target);
        queue_byte(src);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom);
        end while (b == SYM_START || b == SYM_STOP);
        return b;
    endfunction

    function automatic logic [7:0] bcd_digits();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    function automatic logic [7:0] pick_target();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return own_addr;
        if (roll < 85) return ADDR_BCAST;
        return 8'($urandom);
    endfunction

    // One random sequence: mostly a well-formed frame, else noise or breakage
    task automatic queue_random_frame();
        int unsigned roll;
        int unsigned dlen;
        logic [7:0]  op;
        bit          as_bcd;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
            return;
        end
        if (roll < 10) begin
            queue_request(CMD_TICK, 8'($urandom));
            return;
        end
        queue_byte(SYM_START);
        queue_byte(roll < 13 ? 8'($urandom) : SYM_START);
        queue_byte(pick_target());
        queue_byte(roll < 16 ? 8'($urandom) : plain_byte());

        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            op = SYM_OK;
        end else if (roll < 20) begin
            op = SYM_NG;
        end else if (roll < 30) begin
            op = CMD_EXT;
        end else if (roll < 50) begin
            op = SUBCMD_OPS[8*$urandom_range(0, 12) +: 8];
        end else if (roll < 52) begin
            op = SYM_STOP;
        end else begin
            op = plain_byte();
        end
        queue_byte(op);
        if (op == SYM_STOP) return;

        // Subcommand bytes, sometimes cut short by the stop byte
        if (has_subcmd(op)) begin
            if ($urandom_range(0, 15) == 0) begin
                queue_byte(SYM_STOP);
                return;
            end
            if (op == CMD_EXT && $urandom_range(0, 1) == 0) begin
                queue_byte(SUB_EXT);
                if ($urandom_range(0, 7) == 0) begin
                    queue_byte(SYM_STOP);
                    return;
                end
                queue_byte(plain_byte());
                queue_byte(plain_byte());
            end else begin
                queue_byte(plain_byte());
            end
        end

        if (op == SYM_OK || op == SYM_NG) begin
            dlen = $urandom_range(0, 2);
        end else begin
            case ($urandom_range(0, 9))
                0:       dlen = 0;
                1, 2:    dlen = 1;
                3, 4:    dlen = 2;
                5, 6:    dlen = 5;
                7:       dlen = $urandom_range(3, 9);
                8:       dlen = $urandom_range(0, 12);
                default: dlen = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 30) : 8;
            endcase
        end
        as_bcd = 1'($urandom_range(0, 1));
        repeat (dlen) begin
            if ($urandom_range(0, 99) == 0) begin
                queue_byte(8'($urandom));
            end else begin
                queue_byte(as_bcd ? bcd_digits() : plain_byte());
            end
        end
        if ($urandom_range(0, 49) != 0) queue_byte(SYM_STOP);
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned target;
        target = items_queued + count;
        while (items_queued < target) queue_random_frame();
    endtask

    // Wait until all requests are taken and all outcomes seen; end an open frame
    task automatic drain();
        forever begin
            @(posedge i_clk);
            while (requests_queued.size() != 0 || in_ch.valid || results_due.size() != 0) begin
                @(posedge i_clk);
            end
            if (rx_phase == PH_IDLE) break;
            // A start byte ends a frame in collection, any other byte ends sync
            queue_request(CMD_BYTE, rx_phase == PH_SYNC ? SYM_STOP : SYM_START);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MASTER) begin
            own_addr = data[7:0];
        end else begin
            tick_limit = data;
        end
    endtask

    task automatic set_regs(input logic [7:0] addr, input logic [15:0] limit);
        write_reg(REG_MASTER, {8'd0, addr});
        write_reg(REG_TIMEOUT, limit);
        settings_seen++;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_MASTER;
        i_cfg_wdata   = '0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = CMD_BYTE;
        in_ch.rx_byte = '0;
        out_ch.ready  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: one frame of each outcome and each way to drop one but a timeout
        queue_request(CMD_TICK, 8'hFF);
        queue_header(8'hE0, 8'hA4);
        queue_byte(SYM_OK);
        queue_byte(SYM_STOP);
        queue_header(ADDR_BCAST, 8'h00);
        queue_byte(SYM_NG);
        queue_byte(8'h11);
        queue_byte(SYM_STOP);
        queue_header(8'hE0, 8'hFF);
        queue_byte(8'h03);
        repeat (5) queue_byte(8'h99);
        queue_byte(SYM_STOP);
        queue_header(8'hE0, 8'h94);
        queue_byte(8'h03);
        repeat (5) queue_byte(8'hFF);
        queue_byte(SYM_STOP);
        queue_header(8'hE0, 8'h94);
        queue_byte(8'h14);
        queue_byte(8'h01);
        queue_byte(8'h02);
        queue_byte(8'h55);
        queue_byte(SYM_STOP);
        queue_header(8'hE0, 8'h94);
        queue_byte(CMD_EXT);
        queue_byte(SUB_EXT);
        queue_byte(8'h00);
        queue_byte(8'h12);
        queue_byte(8'h80);
        queue_byte(SYM_STOP);
        // Truncated extended command
        queue_header(8'hE0, 8'h94);
        queue_byte(CMD_EXT);
        queue_byte(SUB_EXT);
        queue_byte(8'h00);
        queue_byte(SYM_STOP);
        // Stop before the command byte
        queue_header(8'hE0, 8'h94);
        queue_byte(SYM_STOP);
        // Bad target that is a stop byte, bad second byte, stray start
        queue_byte(SYM_START);
        queue_byte(SYM_START);
        queue_byte(SYM_STOP);
        queue_byte(SYM_START);
        queue_byte(8'h00);
        queue_header(8'hE0, 8'h94);
        queue_byte(8'h03);
        queue_byte(SYM_START);
        // Tick inside a frame, below the limit
        queue_header(8'hE0, 8'h94);
        queue_byte(8'h00);
        queue_request(CMD_TICK, 8'h00);
        queue_byte(8'h01);
        queue_byte(SYM_STOP);
        // Longest legal frame, then one byte too many
        queue_header(8'hE0, 8'h94);
        queue_byte(8'h03);
        repeat (26) queue_byte(plain_byte());
        queue_byte(SYM_STOP);
        queue_header(8'hE0, 8'h94);
        queue_byte(8'h27);
        repeat (27) queue_byte(plain_byte());
        queue_byte(SYM_STOP);
        tick_pct = 2;
        queue_random(RANDOM_ITEMS);
        drain();

        // Broadcast-only address, shortest timeout
        set_regs(8'h00, 16'd1);
        tick_pct = 0;
        queue_byte(SYM_START);
        queue_request(CMD_TICK, 8'h00);
        queue_header(ADDR_BCAST, 8'h11);
        queue_request(CMD_TICK, 8'h00);
        tick_pct = 3;
        queue_random(RANDOM_ITEMS);
        drain();

        // Highest address, longest timeout
        set_regs(8'hFF, 16'hFFFF);
        queue_header(8'hFF, 8'h42);
        queue_byte(SYM_OK);
        queue_byte(SYM_STOP);
        tick_pct = 10;
        queue_random(RANDOM_ITEMS);
        drain();

        // Random address, short timeouts under frequent ticks
        set_regs(8'($urandom), 16'($urandom_range(2, 12)));
        tick_pct = 25;
        queue_random(RANDOM_ITEMS);
        drain();

        if (results_due.size() != 0) begin
            $error("%0d frame outcomes never arrived", results_due.size());
            fail_count++;
        end
        $display("covered %0d requests and %0d outcomes:",
                 requests_taken, status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3]);
        $display("ok %0d, data %0d, rejected %0d, dropped %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("register settings visited: %0d, both ends of address and timeout ranges",
                 settings_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
